>>> hw/rtl/igmpfc_pkg.sv
// ----------------------------------------------------------------------------
// igmpfc_pkg
// Shared types and constants of the IGMP frame classifier.
// ----------------------------------------------------------------------------
package igmpfc_pkg;

	localparam int unsigned LENGTH_COUNT_BITS = 14;
	localparam logic [LENGTH_COUNT_BITS-1:0] POS_MAX = '1;
	localparam logic [13:0] MAX_LEN_RESET = 14'd1500;
	localparam int unsigned QUEUE_DEPTH = 2;

	typedef enum logic [2:0] {
		ST_MAC_FILTERED = 3'd0,
		ST_BAD_IP_SUM   = 3'd1,
		ST_MALFORMED    = 3'd2,
		ST_NOT_IGMP     = 3'd3,
		ST_TOO_LONG     = 3'd4,
		ST_BAD_IGMP_SUM = 3'd5,
		ST_ACCEPTED     = 3'd6,
		ST_TRUNCATED    = 3'd7
	} status_t;

	typedef enum logic [2:0] {
		MK_GENERAL_QUERY = 3'd0,
		MK_GROUP_QUERY   = 3'd1,
		MK_V1_REPORT     = 3'd2,
		MK_V2_REPORT     = 3'd3,
		MK_LEAVE         = 3'd4,
		MK_UNKNOWN       = 3'd5
	} kind_t;

	localparam logic [7:0] IGMP_QUERY     = 8'h11;
	localparam logic [7:0] IGMP_V1_REPORT = 8'h12;
	localparam logic [7:0] IGMP_V2_REPORT = 8'h16;
	localparam logic [7:0] IGMP_LEAVE     = 8'h17;
	localparam logic [7:0] PROTO_IGMP     = 8'h02;
	localparam logic [15:0] ETYPE_IPV4    = 16'h0800;
	localparam logic [7:0] MCAST_FIRST    = 8'h01;

	localparam logic [0:0] REG_STATION_MAC = 1'd0;
	localparam logic [0:0] REG_MAX_LEN     = 1'd1;

	// Frame summary handed from the front to the back part.
	typedef struct packed {
		status_t     status;
		logic [7:0]  type_code;
		logic [31:0] src;
		logic [31:0] dst;
		logic [31:0] grp;
	} verdict_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [2:0]  message_kind;
		logic [7:0]  igmp_type_code;
		logic [31:0] source_ip;
		logic [31:0] dest_ip;
		logic [31:0] group_ip;
	} result_t;

	function automatic logic [15:0] fold_add(input logic [15:0] acc, input logic [15:0] v);
		logic [16:0] s;
		s = {1'b0, acc} + {1'b0, v};
		return s[15:0] + {15'd0, s[16]};
	endfunction

endpackage

>>> hw/rtl/igmpfc_if.sv
// ----------------------------------------------------------------------------
// igmpfc_byte_if / igmpfc_result_if
// Valid/ready channels for frame bytes and classification results.
// ----------------------------------------------------------------------------
interface igmpfc_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte;
	logic       frame_end;
	modport source (output valid, frame_byte, frame_end, input ready);
	modport sink (input valid, frame_byte, frame_end, output ready);
endinterface

interface igmpfc_result_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [2:0]  message_kind;
	logic [7:0]  igmp_type_code;
	logic [31:0] source_ip;
	logic [31:0] dest_ip;
	logic [31:0] group_ip;
	modport source (output valid, status, message_kind, igmp_type_code, source_ip, dest_ip,
		group_ip, input ready);
	modport sink (input valid, status, message_kind, igmp_type_code, source_ip, dest_ip,
		group_ip, output ready);
endinterface

>>> hw/rtl/igmpfc_front.sv
// ----------------------------------------------------------------------------
// igmpfc_front
// Parses frame bytes, accumulates checksums and decides frame status.
// ----------------------------------------------------------------------------
module igmpfc_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic [7:0]              in_byte,
	input  logic                    in_end,
	input  logic [47:0]             station_mac,
	input  logic [13:0]             max_frame_len,
	output logic                    fire,
	output igmpfc_pkg::verdict_t    verdict
);
	import igmpfc_pkg::*;

	localparam int unsigned PB = LENGTH_COUNT_BITS;

	logic [PB-1:0] pos_q;
	logic [3:0]    ihl_q, ver_q;
	logic [15:0]   tlen_q;
	logic [7:0]    proto_q, type_q;
	logic          mac_ok_q, grp_dest_q;
	logic [15:0]   etype_q, ipsum_q, iprx_q, igsum_q, igrx_q;
	logic [31:0]   src_q, dst_q, grp_q;

	// Header offset o = pos - 14 (valid when pos >= 14); wide enough for any pos.
	logic          in_ip;
	logic [16:0]   o, h, j;
	logic [3:0]    ihl_cur;
	logic          in_hdr, in_pay;
	logic [7:0]    want;
	logic [2:0]    mac_idx;

	assign in_ip  = pos_q >= PB'(14);
	assign o      = 17'(pos_q) - 17'd14;
	// header length takes effect on the byte that carries it
	assign ihl_cur = (in_ip && o == 17'd0) ? in_byte[3:0] : ihl_q;
	assign h      = {11'd0, ihl_cur, 2'b00};
	assign j      = o - h;
	assign in_hdr = in_ip && (o < h) && (o != 17'd10) && (o != 17'd11);
	assign in_pay = in_ip && (o >= h) && (o < {1'b0, tlen_q});
	assign mac_idx = 3'(pos_q[2:0]);
	always_comb begin
		unique case (mac_idx)
			3'd0: want = station_mac[47:40];
			3'd1: want = station_mac[39:32];
			3'd2: want = station_mac[31:24];
			3'd3: want = station_mac[23:16];
			3'd4: want = station_mac[15:8];
			default: want = station_mac[7:0];
		endcase
	end

	logic [15:0] ip_word, ig_word;
	assign ip_word = o[0] ? {8'd0, in_byte} : {in_byte, 8'd0};
	assign ig_word = j[0] ? {8'd0, in_byte} : {in_byte, 8'd0};

	// Classification on the final byte, with that byte's updates folded in.
	logic [PB-1:0] pos_n;
	logic [3:0]    ihl_n, ver_n;
	logic [15:0]   tlen_n, ipsum_n, iprx_n, igsum_n, igrx_n;
	logic [7:0]    proto_n, type_n;
	logic          mac_ok_n, grp_dest_n;
	logic [15:0]   etype_n;
	logic [31:0]   src_n, dst_n, grp_n;

	always_comb begin
		ihl_n = ihl_q; ver_n = ver_q; tlen_n = tlen_q; proto_n = proto_q;
		iprx_n = iprx_q; ipsum_n = ipsum_q; igsum_n = igsum_q; igrx_n = igrx_q;
		type_n = type_q; mac_ok_n = mac_ok_q; grp_dest_n = grp_dest_q;
		etype_n = etype_q; src_n = src_q; dst_n = dst_q; grp_n = grp_q;
		if (pos_q < PB'(6)) begin
			if (in_byte != want) mac_ok_n = 1'b0;
			if (pos_q == '0 && in_byte == MCAST_FIRST) grp_dest_n = 1'b1;
		end else if (pos_q == PB'(12)) begin
			etype_n = {in_byte, 8'd0};
		end else if (pos_q == PB'(13)) begin
			etype_n = {etype_q[15:8], in_byte};
		end else if (in_ip) begin
			priority case (1'b1)
				o == 17'd0: begin
					ver_n = in_byte[7:4];
					ihl_n = in_byte[3:0];
				end
				o == 17'd2: tlen_n = {in_byte, tlen_q[7:0]};
				o == 17'd3: tlen_n = {tlen_q[15:8], in_byte};
				o == 17'd9: proto_n = in_byte;
				o == 17'd10: iprx_n = {in_byte, iprx_q[7:0]};
				o == 17'd11: iprx_n = {iprx_q[15:8], in_byte};
				o >= 17'd12 && o < 17'd16: src_n[8*(3-o[1:0]) +: 8] = in_byte;
				o >= 17'd16 && o < 17'd20: dst_n[8*(3-o[1:0]) +: 8] = in_byte;
				default: ;
			endcase
			if (in_hdr) ipsum_n = fold_add(ipsum_q, ip_word);
			if (in_pay) begin
				if (j == 17'd2) igrx_n = {in_byte, igrx_q[7:0]};
				else if (j == 17'd3) igrx_n = {igrx_q[15:8], in_byte};
				else igsum_n = fold_add(igsum_q, ig_word);
				if (j == 17'd0) type_n = in_byte;
				else if (j >= 17'd4 && j < 17'd8) grp_n[8*(3-j[1:0]) +: 8] = in_byte;
			end
		end
	end

	assign pos_n = (pos_q < POS_MAX) ? pos_q + PB'(1) : pos_q;

	logic [16:0] len, hn, need;
	status_t     st;
	assign len  = 17'(pos_q) + 17'd1;
	assign hn   = {11'd0, ihl_n, 2'b00};
	assign need = (hn > 17'd20) ? hn : 17'd20;
	always_comb begin
		priority if (len < 17'd14) st = ST_TRUNCATED;
		else if (etype_n != ETYPE_IPV4 || !(mac_ok_n || grp_dest_n)) st = ST_MAC_FILTERED;
		else if (len < 17'd14 + need) st = ST_TRUNCATED;
		else if (~ipsum_n != iprx_n) st = ST_BAD_IP_SUM;
		else if (tlen_n < 16'd20 || ver_n != 4'd4 || ihl_n < 4'd5) st = ST_MALFORMED;
		else if (proto_n != PROTO_IGMP) st = ST_NOT_IGMP;
		else if (pos_q == POS_MAX || len > 17'(max_frame_len)) st = ST_TOO_LONG;
		else if ({1'b0, tlen_n} < hn + 17'd8) st = ST_MALFORMED;
		else if (len < 17'd14 + {1'b0, tlen_n}) st = ST_TRUNCATED;
		else if (~igsum_n != igrx_n) st = ST_BAD_IGMP_SUM;
		else st = ST_ACCEPTED;
	end

	assign fire = in_valid && in_end;
	always_comb begin
		verdict.status    = st;
		verdict.type_code = type_n;
		verdict.src       = src_n;
		verdict.dst       = dst_n;
		verdict.grp       = grp_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0; ihl_q <= '0; ver_q <= '0; tlen_q <= '0; proto_q <= '0;
			mac_ok_q <= 1'b1; grp_dest_q <= 1'b0; etype_q <= '0; ipsum_q <= '0;
			iprx_q <= '0; igsum_q <= '0; igrx_q <= '0; type_q <= '0;
			src_q <= '0; dst_q <= '0; grp_q <= '0;
		end else if (in_valid) begin
			if (in_end) begin
				pos_q <= '0; ihl_q <= '0; ver_q <= '0; tlen_q <= '0; proto_q <= '0;
				mac_ok_q <= 1'b1; grp_dest_q <= 1'b0; etype_q <= '0; ipsum_q <= '0;
				iprx_q <= '0; igsum_q <= '0; igrx_q <= '0; type_q <= '0;
				src_q <= '0; dst_q <= '0; grp_q <= '0;
			end else begin
				pos_q <= pos_n; ihl_q <= ihl_n; ver_q <= ver_n; tlen_q <= tlen_n;
				proto_q <= proto_n; mac_ok_q <= mac_ok_n; grp_dest_q <= grp_dest_n;
				etype_q <= etype_n; ipsum_q <= ipsum_n; iprx_q <= iprx_n;
				igsum_q <= igsum_n; igrx_q <= igrx_n; type_q <= type_n;
				src_q <= src_n; dst_q <= dst_n; grp_q <= grp_n;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_end |=> pos_q == '0 && mac_ok_q)
		else $error("frame state not cleared after frame end");
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_end && pos_q < POS_MAX |=> pos_q == $past(pos_q) + PB'(1))
		else $error("byte position did not advance");
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_valid |=> $stable(pos_q))
		else $error("byte position moved without a byte");

endmodule

>>> hw/rtl/igmpfc_queue.sv
// ----------------------------------------------------------------------------
// igmpfc_queue
// Short FIFO of frame verdicts between front and back parts.
// ----------------------------------------------------------------------------
module igmpfc_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  igmpfc_pkg::verdict_t push_data,
	output logic                 full,
	output logic                 empty,
	input  logic                 pop,
	output igmpfc_pkg::verdict_t pop_data
);
	import igmpfc_pkg::*;

	localparam int unsigned AW = $clog2(QUEUE_DEPTH);

	verdict_t        mem_q [QUEUE_DEPTH];
	logic [AW-1:0]   wr_q, rd_q;
	logic [AW:0]     cnt_q;

	assign full     = cnt_q == (AW+1)'(QUEUE_DEPTH);
	assign empty    = cnt_q == '0;
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push && !full) mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0; rd_q <= '0; cnt_q <= '0;
		end else begin
			if (push && !full) wr_q <= (wr_q == AW'(QUEUE_DEPTH-1)) ? '0 : wr_q + AW'(1);
			if (pop && !empty) rd_q <= (rd_q == AW'(QUEUE_DEPTH-1)) ? '0 : rd_q + AW'(1);
			cnt_q <= cnt_q + (AW+1)'(push && !full) - (AW+1)'(pop && !empty);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= (AW+1)'(QUEUE_DEPTH))
		else $error("queue count overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		full && !pop |=> full)
		else $error("full queue lost an entry");

endmodule

>>> hw/rtl/igmpfc_back.sv
// ----------------------------------------------------------------------------
// igmpfc_back
// Classifies the message kind and masks fields into the output register.
// ----------------------------------------------------------------------------
module igmpfc_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 empty,
	input  igmpfc_pkg::verdict_t data,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output igmpfc_pkg::result_t  result
);
	import igmpfc_pkg::*;

	logic    valid_q;
	result_t res_q, res_n;
	logic    load;
	kind_t   kind;
	logic    acc, addr_ok;

	assign acc     = data.status == ST_ACCEPTED;
	assign addr_ok = data.status != ST_MAC_FILTERED && data.status != ST_TRUNCATED;
	always_comb begin
		unique case (data.type_code)
			IGMP_QUERY:     kind = (data.grp == '0) ? MK_GENERAL_QUERY : MK_GROUP_QUERY;
			IGMP_V1_REPORT: kind = MK_V1_REPORT;
			IGMP_V2_REPORT: kind = MK_V2_REPORT;
			IGMP_LEAVE:     kind = MK_LEAVE;
			default:        kind = MK_UNKNOWN;
		endcase
		res_n.status         = data.status;
		res_n.message_kind   = acc ? kind : MK_GENERAL_QUERY;
		res_n.igmp_type_code = acc ? data.type_code : 8'd0;
		res_n.group_ip       = acc ? data.grp : 32'd0;
		res_n.source_ip      = addr_ok ? data.src : 32'd0;
		res_n.dest_ip        = addr_ok ? data.dst : 32'd0;
	end

	assign load      = !empty && (!valid_q || out_ready);
	assign pop       = load;
	assign out_valid = valid_q;
	assign result    = res_q;

	always_ff @(posedge clk) begin
		if (load) res_q <= res_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_q <= 1'b0;
		else if (load) valid_q <= 1'b1;
		else if (out_ready) valid_q <= 1'b0;
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !out_ready |=> valid_q && $stable(res_q))
		else $error("stalled result changed");

endmodule

>>> hw/rtl/igmp_frame_classifier.sv
// ----------------------------------------------------------------------------
// igmp_frame_classifier
// IPv4/IGMP frame validator with APB configuration.
// ----------------------------------------------------------------------------
// Takes one frame byte per cycle, starting at the destination MAC, and gives
// one status transaction for each frame after its last byte. The front part
// parses and checks bytes at full rate with no stall of its own; on the last
// byte its verdict goes into a two-entry queue. The back part works out the
// message kind and holds the result in an output register, which is loaded
// from the queue head while it is empty or the sink takes it. Input ready
// drops only while the queue is full, so with a ready sink the sustained rate
// is one byte per cycle.
// Registers: 0x00 station_mac (48 bits), 0x08 max_frame_len (reset 1500),
// 64-bit data, byte address 8*index.
// ----------------------------------------------------------------------------
module igmp_frame_classifier (
	input  logic            clk,
	input  logic            arst_n,
	igmpfc_byte_if.sink     frame,
	igmpfc_result_if.source result,
	input  logic            psel,
	input  logic            penable,
	input  logic            pwrite,
	input  logic [3:0]      paddr,
	input  logic [63:0]     pwdata,
	output logic [63:0]     prdata,
	output logic            pready
);
	import igmpfc_pkg::*;

	logic [47:0] mac_q;
	logic [13:0] maxlen_q;
	logic        fire, full, empty, pop, wr;
	verdict_t    v_in, v_out;
	result_t     res;

	// Register file: index is paddr[3].
	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mac_q    <= '0;
			maxlen_q <= MAX_LEN_RESET;
		end else if (wr) begin
			if (paddr[3] == REG_STATION_MAC) mac_q <= pwdata[47:0];
			else maxlen_q <= pwdata[13:0];
		end
	end
	assign prdata = (paddr[3] == REG_MAX_LEN) ? {50'd0, maxlen_q} : {16'd0, mac_q};

	// Stall bytes only while a final byte could not push.
	assign frame.ready = !full;

	igmpfc_front u_front (
		.clk, .arst_n,
		.in_valid(frame.valid && !full), .in_byte(frame.frame_byte),
		.in_end(frame.frame_end), .station_mac(mac_q), .max_frame_len(maxlen_q),
		.fire, .verdict(v_in)
	);

	igmpfc_queue u_queue (
		.clk, .arst_n, .push(fire), .push_data(v_in), .full, .empty,
		.pop, .pop_data(v_out)
	);

	igmpfc_back u_back (
		.clk, .arst_n, .empty, .data(v_out), .pop,
		.out_valid(result.valid), .out_ready(result.ready), .result(res)
	);

	assign result.status         = res.status;
	assign result.message_kind   = res.message_kind;
	assign result.igmp_type_code = res.igmp_type_code;
	assign result.source_ip      = res.source_ip;
	assign result.dest_ip        = res.dest_ip;
	assign result.group_ip       = res.group_ip;

	assert property (@(posedge clk) disable iff (!arst_n)
		frame.valid && frame.ready && frame.frame_end |-> fire)
		else $error("final byte did not push a verdict");
	assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> result.valid)
		else $error("popped verdict not presented");

endmodule
